// File: hw/rtl/ttlp_pkg.sv
// Shared constants and control/status types for the tournament tree leaf probability core.
package ttlp_pkg;

  localparam int LEAVES_MAX = 64;
  localparam int INNER_MAX  = LEAVES_MAX - 1;
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int PROB_W     = 16;

  localparam logic [PROB_W-1:0] ONE_Q15 = 16'h8000;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  localparam logic REG_LEAF_COUNT = 1'b0;

  typedef struct packed {
    logic load;
    logic rb_step;
    logic init;
    logic node_rd;
    logic mul;
    logic wr_l;
    logic wr_r;
    logic emit_start;
    logic emit_rd;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic n_lt2;
    logic rb_done;
    logic node_last;
    logic emit_last;
  } sts_t;

endpackage

// File: hw/rtl/ttlp_ctrl.sv
// Controller: sequences load, rebuild, node walk and score emission.
module ttlp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_kind,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  ttlp_pkg::sts_t sts,
  output ttlp_pkg::cmd_t cmd
);
  import ttlp_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_REBUILD = 4'd1;
  localparam logic [3:0] ST_INIT    = 4'd2;
  localparam logic [3:0] ST_RD      = 4'd3;
  localparam logic [3:0] ST_MUL     = 4'd4;
  localparam logic [3:0] ST_WL      = 4'd5;
  localparam logic [3:0] ST_WR      = 4'd6;
  localparam logic [3:0] ST_ERD     = 4'd7;
  localparam logic [3:0] ST_EOUT    = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE) && !sts.cfg_wr;
  assign out_tvalid = (state_r == ST_EOUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.cfg_wr) begin
          state_nxt = ST_REBUILD;
        end else if (in_tvalid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load = 1'b1;
          end else if (sts.n_lt2) begin
            cmd.emit_start = 1'b1;
            state_nxt      = ST_EOUT;
          end else begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_REBUILD: begin
        if (sts.rb_done) state_nxt = ST_IDLE;
        else             cmd.rb_step = 1'b1;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.node_rd = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_WL;
      end
      ST_WL: begin
        cmd.wr_l  = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr_r = 1'b1;
        if (sts.node_last) begin
          cmd.emit_start = 1'b1;
          state_nxt      = ST_ERD;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_ERD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EOUT;
      end
      ST_EOUT: begin
        if (out_tready) begin
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = ST_ERD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/ttlp_dp.sv
// Datapath: register file, tree builder, node stores, Q1.15 multipliers, score store.
module ttlp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [2:0]                        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  input  logic [ttlp_pkg::IDX_W-1:0]        in_node_index,
  input  logic [ttlp_pkg::PROB_W-1:0]       in_left_prob,
  input  logic [ttlp_pkg::PROB_W-1:0]       in_right_prob,
  output logic [ttlp_pkg::IDX_W-1:0]        out_action,
  output logic [ttlp_pkg::PROB_W-1:0]       out_score,
  output logic                              out_last,
  output logic                              out_empty,
  input  ttlp_pkg::cmd_t                    cmd,
  output ttlp_pkg::sts_t                    sts
);
  import ttlp_pkg::*;

  logic [CNT_W-1:0] leaf_cnt_r;
  logic [CNT_W-1:0] wr_cnt;
  logic             cfg_wr;

  // tree builder: current round = [base, base+cnt) plus an optional carried entrant
  logic [CNT_W-1:0] rb_base_r, rb_cnt_r, rb_carry_r, rb_start_r, rb_id_r;
  logic             rb_cv_r;
  logic [IDX_W-1:0] rb_j_r;
  logic [CNT_W-1:0] rb_ncur, rb_last_i;
  logic [IDX_W-1:0] rb_pairs;
  logic [CNT_W-1:0] rb_lc, rb_rc, rb_carry_nxt, rb_k;

  logic [CNT_W-1:0]  lc_mem [INNER_MAX];
  logic [CNT_W-1:0]  rc_mem [INNER_MAX];
  logic [PROB_W-1:0] sl_mem [INNER_MAX];
  logic [PROB_W-1:0] sr_mem [INNER_MAX];
  logic [PROB_W-1:0] pw_mem [INNER_MAX];
  logic [PROB_W-1:0] sc_mem [LEAVES_MAX];

  logic [CNT_W-1:0]  lc_q, rc_q;
  logic [PROB_W-1:0] sl_q, sr_q, pw_q, sc_q;
  logic [PROB_W-1:0] eff_l_r, eff_r_r;
  logic [2*PROB_W-1:0] prod_l, prod_r;

  logic [IDX_W-1:0] k_r, ej_r;
  logic             spec_r;
  logic [IDX_W-1:0] node_n, root_n;

  logic [CNT_W-1:0]  wchild;
  logic [PROB_W-1:0] weff;
  logic              wchild_leaf;
  logic [CNT_W-1:0]  wchild_inner;

  function automatic logic [CNT_W-1:0] entrant(input logic [CNT_W-1:0] i,
                                               input logic [CNT_W-1:0] base,
                                               input logic [CNT_W-1:0] cnt,
                                               input logic [CNT_W-1:0] carry);
    entrant = (i < cnt) ? CNT_W'(base + i) : carry;
  endfunction

  function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] v);
    sat_prob = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_LEAF_COUNT);
  assign wr_cnt     = (cfg_pwdata[CNT_W-1:0] > CNT_W'(LEAVES_MAX)) ? CNT_W'(LEAVES_MAX)
                                                                  : cfg_pwdata[CNT_W-1:0];
  assign cfg_prdata = {{(32-CNT_W){1'b0}}, leaf_cnt_r};

  assign rb_ncur      = rb_cnt_r + CNT_W'(rb_cv_r);
  assign rb_pairs     = rb_ncur[CNT_W-1:1];
  assign rb_last_i    = rb_ncur - CNT_W'(1);
  assign rb_lc        = entrant({rb_j_r, 1'b0}, rb_base_r, rb_cnt_r, rb_carry_r);
  assign rb_rc        = entrant({rb_j_r, 1'b1}, rb_base_r, rb_cnt_r, rb_carry_r);
  assign rb_carry_nxt = entrant(rb_last_i, rb_base_r, rb_cnt_r, rb_carry_r);
  assign rb_k         = rb_id_r - leaf_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_cnt_r <= '0;
    end else if (cfg_wr) begin
      leaf_cnt_r <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      rb_base_r  <= '0;
      rb_cnt_r   <= wr_cnt;
      rb_cv_r    <= 1'b0;
      rb_carry_r <= '0;
      rb_j_r     <= '0;
      rb_start_r <= wr_cnt;
      rb_id_r    <= wr_cnt;
    end else if (cmd.rb_step) begin
      if (rb_j_r < rb_pairs) begin
        lc_mem[rb_k[IDX_W-1:0]] <= rb_lc;
        rc_mem[rb_k[IDX_W-1:0]] <= rb_rc;
        rb_id_r <= rb_id_r + CNT_W'(1);
        rb_j_r  <= rb_j_r + IDX_W'(1);
      end else begin
        // round closes: new nodes become the entrants, odd one carried on
        rb_base_r  <= rb_start_r;
        rb_cnt_r   <= CNT_W'(rb_pairs);
        rb_cv_r    <= rb_ncur[0];
        rb_carry_r <= rb_carry_nxt;
        rb_start_r <= rb_id_r;
        rb_j_r     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (leaf_cnt_r >= CNT_W'(2)) &&
        ({1'b0, in_node_index} < (leaf_cnt_r - CNT_W'(1)))) begin
      sl_mem[in_node_index] <= sat_prob(in_left_prob);
      sr_mem[in_node_index] <= sat_prob(in_right_prob);
    end
  end

  assign node_n = k_r - IDX_W'(1);
  assign root_n = IDX_W'(leaf_cnt_r - CNT_W'(2));

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      k_r <= IDX_W'(leaf_cnt_r - CNT_W'(1));
    end else if (cmd.wr_r) begin
      k_r <= k_r - IDX_W'(1);
    end
    if (cmd.node_rd) begin
      lc_q <= lc_mem[node_n];
      rc_q <= rc_mem[node_n];
      sl_q <= sl_mem[node_n];
      sr_q <= sr_mem[node_n];
      pw_q <= pw_mem[node_n];
    end
    if (cmd.mul) begin
      eff_l_r <= prod_l[PROB_W+14:15];
      eff_r_r <= prod_r[PROB_W+14:15];
    end
  end

  assign prod_l = sl_q * pw_q;
  assign prod_r = sr_q * pw_q;

  assign wchild       = cmd.wr_l ? lc_q : rc_q;
  assign weff         = cmd.wr_l ? eff_l_r : eff_r_r;
  assign wchild_leaf  = (wchild < leaf_cnt_r);
  assign wchild_inner = wchild - leaf_cnt_r;

  // parent weight of each node; the root starts at one
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      pw_mem[root_n] <= ONE_Q15;
    end else if ((cmd.wr_l || cmd.wr_r) && !wchild_leaf) begin
      pw_mem[wchild_inner[IDX_W-1:0]] <= weff;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.wr_l || cmd.wr_r) && wchild_leaf) begin
      sc_mem[wchild[IDX_W-1:0]] <= weff;
    end
    if (cmd.emit_rd) begin
      sc_q <= sc_mem[ej_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spec_r <= 1'b0;
      ej_r   <= '0;
    end else if (cmd.emit_start) begin
      spec_r <= (leaf_cnt_r < CNT_W'(2));
      ej_r   <= '0;
    end else if (cmd.emit_next) begin
      ej_r <= ej_r + IDX_W'(1);
    end
  end

  assign out_action = ej_r;
  assign out_score  = spec_r ? ((leaf_cnt_r == '0) ? '0 : ONE_Q15) : sc_q;
  assign out_last   = spec_r || (ej_r == IDX_W'(leaf_cnt_r - CNT_W'(1)));
  assign out_empty  = spec_r && (leaf_cnt_r == '0);

  assign sts.cfg_wr    = cfg_wr;
  assign sts.n_lt2     = (leaf_cnt_r < CNT_W'(2));
  assign sts.rb_done   = (rb_ncur <= CNT_W'(1));
  assign sts.node_last = (k_r == IDX_W'(1));
  assign sts.emit_last = out_last;

endmodule

// File: hw/rtl/tournament_tree_leaf_probability_core.sv
// Tournament tree leaf probability core: top level.
//
// Config: APB register 0 (byte address 0) holds the leaf count N (low 7 bits written, clamped to 64).
// Writing it rebuilds the tree, one internal node per cycle plus a closing step
// for each round, while in_tready is low.
// Input requests: tuser selects load (0) or compute (1). A load stores one
// internal node's left/right probabilities (saturated to 1.0) if node_index < N - 1.
// A compute walks the internal nodes root first, each by a read, a multiply,
// a write of the left child and a write of the right child (through the
// single-port weight and score memories), then emits N results, each by a
// score memory read and then an output held until it is taken.
// N = 0 gives one result with tuser set; N = 1 gives one result of 1.0.
// tlast marks the final result of a compute request.
// One request is handled at a time; in_tready is low until the last result
// is taken. A stalled receiver holds out_tdata, out_tlast and out_tuser.
// Reset (synchronous) clears N to 0 and returns the controller to idle.
module tournament_tree_leaf_probability_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // node_index[5:0], left_prob[21:6], right_prob[37:22], zero
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // action[5:0], score[21:6], zero
  output logic        out_tlast,
  output logic        out_tuser   // empty_res
);
  import ttlp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [IDX_W-1:0]  action;
  logic [PROB_W-1:0] score;

  assign cfg_pready = 1'b1;

  ttlp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ttlp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .in_node_index (in_tdata[5:0]),
    .in_left_prob  (in_tdata[21:6]),
    .in_right_prob (in_tdata[37:22]),
    .out_action    (action),
    .out_score     (score),
    .out_last      (out_tlast),
    .out_empty     (out_tuser),
    .cmd           (cmd),
    .sts           (sts)
  );

  assign out_tdata = {2'b00, score, action};

  a_busy_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast) else $error("empty result not last");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[21:6] == '0)) else $error("empty score nonzero");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("result after last");

endmodule
